// ===== hw/rtl/aofbt_pkg.sv =====
package aofbt_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ADDR_BITS_DEF  = 16;
  localparam int OWNER_BITS_DEF = 8;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 2;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_BITS-1:0] OP_COALESCE   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_FIND_SIZE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_FIND_OWNER = 3'd3;
  localparam logic [OP_BITS-1:0] OP_REMOVE_AT  = 3'd4;
  localparam logic [OP_BITS-1:0] OP_READ_AT    = 3'd5;
  localparam logic [OP_BITS-1:0] OP_FIND_EXACT = 3'd6;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

  // read address select
  localparam logic [1:0] RD_PTR   = 2'd0;
  localparam logic [1:0] RD_PTRM1 = 2'd1;
  localparam logic [1:0] RD_PTRP1 = 2'd2;

  // write select
  localparam logic [1:0] WR_SHIFT = 2'd0;
  localparam logic [1:0] WR_NEW   = 2'd1;
  localparam logic [1:0] WR_KEEP  = 2'd2;

  // pointer update
  localparam logic [1:0] PTR_HOLD = 2'd0;
  localparam logic [1:0] PTR_INC  = 2'd1;
  localparam logic [1:0] PTR_DEC  = 2'd2;

  // count update
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_KEEP = 2'd3;

  // result load
  localparam logic [1:0] RES_HOLD  = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_REQ   = 2'd2;
  localparam logic [1:0] RES_RDATA = 2'd3;

  typedef struct packed {
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [1:0] ptr_op;
    logic [1:0] cnt_op;
    logic [1:0] res_op;
    logic       res_zero;
    logic       keep_load;
    logic       keep_merge;
    logic       keep_adv;
    logic       post;
  } aofbt_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               full;
    logic               cnt_lt2;
    logic               ptr_zero;
    logic               ptr_at_cnt;
    logic               slot_oob;
    logic               rm_last;
    logic               ins_shift;
    logic               merge;
    logic               hit;
    logic               out_free;
  } aofbt_sts_t;

endpackage

// ===== hw/rtl/aofbt_ram.sv =====
module aofbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/aofbt_ctrl.sv =====
module aofbt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aofbt_pkg::aofbt_sts_t sts,
  output aofbt_pkg::aofbt_cmd_t cmd
);
  import aofbt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_INS_CHK  = 4'd2;
  localparam logic [3:0] S_INS_EV   = 4'd3;
  localparam logic [3:0] S_CO_START = 4'd4;
  localparam logic [3:0] S_CO_LD    = 4'd5;
  localparam logic [3:0] S_CO_RD    = 4'd6;
  localparam logic [3:0] S_CO_EV    = 4'd7;
  localparam logic [3:0] S_SR_RD    = 4'd8;
  localparam logic [3:0] S_SR_EV    = 4'd9;
  localparam logic [3:0] S_RR_CHK   = 4'd10;
  localparam logic [3:0] S_RR_EV    = 4'd11;
  localparam logic [3:0] S_RM_RD    = 4'd12;
  localparam logic [3:0] S_RM_EV    = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_INSERT:     state_nxt = S_INS_CHK;
          OP_COALESCE:   state_nxt = S_CO_START;
          OP_FIND_SIZE,
          OP_FIND_OWNER,
          OP_FIND_EXACT: state_nxt = S_SR_RD;
          OP_REMOVE_AT,
          OP_READ_AT:    state_nxt = S_RR_CHK;
          default:       state_nxt = S_DONE;
        endcase
      end
      // walk down from the top, moving entries whose start is not below the new one
      S_INS_CHK: begin
        if (sts.full) begin
          cmd.res_op = RES_FULL;
          state_nxt  = S_DONE;
        end else if (sts.ptr_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_NEW;
          cmd.res_op = RES_REQ;
          cmd.cnt_op = CNT_INC;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTRM1;
          state_nxt  = S_INS_EV;
        end
      end
      S_INS_EV: begin
        cmd.wr_en = 1'b1;
        if (sts.ins_shift) begin
          cmd.wr_sel = WR_SHIFT;
          cmd.ptr_op = PTR_DEC;
          state_nxt  = S_INS_CHK;
        end else begin
          cmd.wr_sel = WR_NEW;
          cmd.res_op = RES_REQ;
          cmd.cnt_op = CNT_INC;
          state_nxt  = S_DONE;
        end
      end
      S_CO_START: begin
        if (sts.cnt_lt2) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTRM1;
          state_nxt  = S_CO_LD;
        end
      end
      S_CO_LD: begin
        cmd.keep_load = 1'b1;
        state_nxt     = S_CO_RD;
      end
      S_CO_RD: begin
        if (sts.ptr_at_cnt) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_KEEP;
          cmd.cnt_op   = CNT_KEEP;
          cmd.res_zero = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_nxt  = S_CO_EV;
        end
      end
      S_CO_EV: begin
        cmd.ptr_op = PTR_INC;
        if (sts.merge) begin
          cmd.keep_merge = 1'b1;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WR_KEEP;
          cmd.keep_adv  = 1'b1;
          cmd.keep_load = 1'b1;
        end
        state_nxt = S_CO_RD;
      end
      S_SR_RD: begin
        if (sts.ptr_at_cnt) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_nxt  = S_SR_EV;
        end
      end
      S_SR_EV: begin
        if (sts.hit) begin
          cmd.res_op = RES_RDATA;
          state_nxt  = S_DONE;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_nxt  = S_SR_RD;
        end
      end
      S_RR_CHK: begin
        if (sts.slot_oob) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_nxt  = S_RR_EV;
        end
      end
      S_RR_EV: begin
        cmd.res_op = RES_RDATA;
        state_nxt  = (sts.op == OP_REMOVE_AT) ? S_RM_RD : S_DONE;
      end
      // close the gap by pulling each following entry down one place
      S_RM_RD: begin
        if (sts.rm_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTRP1;
          state_nxt  = S_RM_EV;
        end
      end
      S_RM_EV: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.ptr_op = PTR_INC;
        state_nxt  = S_RM_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH))
    else $error("accepted item did not start dispatch");

  a_post_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> sts.out_free)
    else $error("result posted over a waiting result");

  a_no_rd_and_post: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!cmd.rd_en && !cmd.wr_en))
    else $error("table access while posting");

endmodule

// ===== hw/rtl/aofbt_dp.sv =====
module aofbt_dp #(
  parameter int DEPTH      = aofbt_pkg::DEPTH_DEF,
  parameter int ADDR_BITS  = aofbt_pkg::ADDR_BITS_DEF,
  parameter int OWNER_BITS = aofbt_pkg::OWNER_BITS_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic [aofbt_pkg::OP_BITS-1:0]      in_op,
  input  logic [OWNER_BITS-1:0]              in_owner,
  input  logic [ADDR_BITS-1:0]               in_start,
  input  logic [ADDR_BITS-1:0]               in_end,
  input  logic [ADDR_BITS:0]                 in_size,
  input  logic [IDX_W-1:0]                   in_slot,
  input  aofbt_pkg::aofbt_cmd_t              cmd,
  output aofbt_pkg::aofbt_sts_t              sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [aofbt_pkg::STATUS_BITS-1:0]  out_status,
  output logic [IDX_W-1:0]                   out_index,
  output logic [OWNER_BITS-1:0]              out_owner,
  output logic [ADDR_BITS-1:0]               out_start,
  output logic [ADDR_BITS-1:0]               out_end,
  output logic [CNT_W-1:0]                   out_count
);
  import aofbt_pkg::*;

  localparam int ENT_W = OWNER_BITS + 2 * ADDR_BITS;

  // request
  logic [OP_BITS-1:0]    op_r;
  logic [OWNER_BITS-1:0] own_r;
  logic [ADDR_BITS-1:0]  st_r, en_r;
  logic [ADDR_BITS:0]    want_r;
  logic [IDX_W-1:0]      slot_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] keep_r;
  logic [OWNER_BITS-1:0] kown_r;
  logic [ADDR_BITS-1:0]  kst_r, ken_r;

  // pending result
  logic [STATUS_BITS-1:0] rs_status_r;
  logic [CNT_W-1:0]       rs_index_r;
  logic [OWNER_BITS-1:0]  rs_owner_r;
  logic [ADDR_BITS-1:0]   rs_start_r, rs_end_r;

  logic out_valid_r;
  logic [STATUS_BITS-1:0] o_status_r;
  logic [IDX_W-1:0]       o_index_r;
  logic [OWNER_BITS-1:0]  o_owner_r;
  logic [ADDR_BITS-1:0]   o_start_r, o_end_r;
  logic [CNT_W-1:0]       o_count_r;

  logic [ENT_W-1:0]      rdata, wdata;
  logic [OWNER_BITS-1:0] r_own;
  logic [ADDR_BITS-1:0]  r_st, r_en;
  logic [CNT_W:0]        rd_addr, wr_addr;
  logic [ADDR_BITS+1:0]  fit_lhs, fit_rhs;

  assign {r_own, r_st, r_en} = rdata;

  always_comb begin
    case (cmd.rd_sel)
      RD_PTRM1: rd_addr = {1'b0, ptr_r} - 1'b1;
      RD_PTRP1: rd_addr = {1'b0, ptr_r} + 1'b1;
      default:  rd_addr = {1'b0, ptr_r};
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_NEW:  begin wdata = {own_r, st_r, en_r};    wr_addr = {1'b0, ptr_r}; end
      WR_KEEP: begin
        wdata   = {kown_r, kst_r, ken_r};
        wr_addr = (CNT_W + 1)'(keep_r);
      end
      default: begin wdata = rdata;                  wr_addr = {1'b0, ptr_r}; end
    endcase
  end

  aofbt_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr[IDX_W-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr[IDX_W-1:0]),
    .rdata (rdata)
  );

  // size test: want <= end - start + 1, done without wrap
  assign fit_lhs = {1'b0, want_r} + {2'b00, r_st};
  assign fit_rhs = {2'b00, r_en} + 1'b1;

  always_comb begin
    sts.op         = op_r;
    sts.full       = (cnt_r == CNT_W'(DEPTH));
    sts.cnt_lt2    = (cnt_r < CNT_W'(2));
    sts.ptr_zero   = (ptr_r == '0);
    sts.ptr_at_cnt = (ptr_r == cnt_r);
    sts.slot_oob   = ((CNT_W + 1)'(slot_r) >= {1'b0, cnt_r});
    sts.rm_last    = (({1'b0, ptr_r} + 1'b1) >= {1'b0, cnt_r});
    sts.ins_shift  = (r_st >= st_r);
    sts.merge      = (({1'b0, ken_r} + 1'b1) == {1'b0, r_st});
    case (op_r)
      OP_FIND_SIZE:  sts.hit = (fit_lhs <= fit_rhs);
      OP_FIND_OWNER: sts.hit = (r_own == own_r);
      default:       sts.hit = (r_own == own_r) && (r_st == st_r) && (r_en == en_r);
    endcase
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_INC: ptr_nxt = ptr_r + 1'b1;
      PTR_DEC: ptr_nxt = ptr_r - 1'b1;
      default: ptr_nxt = ptr_r;
    endcase
    case (cmd.cnt_op)
      CNT_INC:  cnt_nxt = cnt_r + 1'b1;
      CNT_DEC:  cnt_nxt = cnt_r - 1'b1;
      CNT_KEEP: cnt_nxt = CNT_W'(keep_r) + 1'b1;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= in_op;
      own_r  <= in_owner;
      st_r   <= in_start;
      en_r   <= in_end;
      want_r <= in_size;
      slot_r <= in_slot;
      case (in_op)
        OP_INSERT:    ptr_r <= cnt_r;
        OP_COALESCE:  ptr_r <= CNT_W'(1);
        OP_REMOVE_AT,
        OP_READ_AT:   ptr_r <= CNT_W'(in_slot);
        default:      ptr_r <= '0;
      endcase
      keep_r      <= '0;
      rs_status_r <= ST_MISS;
      rs_index_r  <= '0;
      rs_owner_r  <= '0;
      rs_start_r  <= '0;
      rs_end_r    <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      if (cmd.keep_adv) keep_r <= keep_r + 1'b1;
      if (cmd.res_zero) rs_status_r <= ST_OK;
      case (cmd.res_op)
        RES_FULL: rs_status_r <= ST_FULL;
        RES_REQ: begin
          rs_status_r <= ST_OK;
          rs_index_r  <= ptr_r;
          rs_owner_r  <= own_r;
          rs_start_r  <= st_r;
          rs_end_r    <= en_r;
        end
        RES_RDATA: begin
          rs_status_r <= ST_OK;
          rs_index_r  <= ptr_r;
          rs_owner_r  <= r_own;
          rs_start_r  <= r_st;
          rs_end_r    <= r_en;
        end
        default: begin
        end
      endcase
    end
    if (cmd.keep_load) begin
      kown_r <= r_own;
      kst_r  <= r_st;
      ken_r  <= r_en;
    end else if (cmd.keep_merge) begin
      ken_r <= r_en;
    end
    if (cmd.post) begin
      o_status_r <= rs_status_r;
      o_index_r  <= rs_index_r[IDX_W-1:0];
      o_owner_r  <= rs_owner_r;
      o_start_r  <= rs_start_r;
      o_end_r    <= rs_end_r;
      o_count_r  <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = o_status_r;
  assign out_index  = o_index_r;
  assign out_owner  = o_owner_r;
  assign out_start  = o_start_r;
  assign out_end    = o_end_r;
  assign out_count  = o_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_INC) |-> (cnt_r < CNT_W'(DEPTH)))
    else $error("insert into full table");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (rd_addr < {1'b0, cnt_r}))
    else $error("read beyond valid entries");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (wr_addr <= {1'b0, cnt_r}) && (wr_addr < (CNT_W + 1)'(DEPTH)))
    else $error("write beyond valid entries");

endmodule

// ===== hw/rtl/address_ordered_free_block_table_unit.sv =====
// address ordered free block table
// keeps up to DEPTH blocks (owner, start, end) sorted by start address in a
// single ram and runs one operation per input item: insert, coalesce, find by
// size (first fit), find by owner, remove at, read at, find exact
// in channel: one operation item, taken when in_tvalid and in_tready are high;
// in_tready is high only while the sequencer is idle
// out channel: one result item per operation, held in an output register until
// out_tready; the next item can be accepted while a result waits there
// table steps: each step is a ram read followed by an evaluate state; an item
// walks the entries one step at a time (insert shift, search, remove shift,
// coalesce scan), as the entry ram has one read port; read at index makes a
// single ram read
// reset: entry count cleared, output empty; entry contents are not cleared
// stall: a finished result waits in the sequencer until the output register
// is free, no result is dropped
module address_ordered_free_block_table_unit #(
  parameter int DEPTH      = aofbt_pkg::DEPTH_DEF,
  parameter int ADDR_BITS  = aofbt_pkg::ADDR_BITS_DEF,
  parameter int OWNER_BITS = aofbt_pkg::OWNER_BITS_DEF,
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int IN_W    = aofbt_pkg::OP_BITS + OWNER_BITS + 3 * ADDR_BITS + 1 + IDX_W,
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W   = aofbt_pkg::STATUS_BITS + IDX_W + OWNER_BITS + 2 * ADDR_BITS + CNT_W,
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // operation, owner_id, block_start, block_end, size_request, slot_index
  input  logic [IN_TW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status, found_index, out_owner, out_start, out_end, entry_count
  output logic [OUT_TW-1:0] out_tdata
);
  import aofbt_pkg::*;

  // input field offsets
  localparam int O_OWN  = OP_BITS;
  localparam int O_ST   = O_OWN + OWNER_BITS;
  localparam int O_EN   = O_ST + ADDR_BITS;
  localparam int O_SZ   = O_EN + ADDR_BITS;
  localparam int O_SLOT = O_SZ + ADDR_BITS + 1;

  aofbt_cmd_t cmd;
  aofbt_sts_t sts;
  logic       load;

  logic [STATUS_BITS-1:0] r_status;
  logic [IDX_W-1:0]       r_index;
  logic [OWNER_BITS-1:0]  r_owner;
  logic [ADDR_BITS-1:0]   r_start, r_end;
  logic [CNT_W-1:0]       r_count;

  assign load = in_tvalid && in_tready;

  aofbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aofbt_dp #(
    .DEPTH      (DEPTH),
    .ADDR_BITS  (ADDR_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .in_op      (in_tdata[OP_BITS-1:0]),
    .in_owner   (in_tdata[O_ST-1:O_OWN]),
    .in_start   (in_tdata[O_EN-1:O_ST]),
    .in_end     (in_tdata[O_SZ-1:O_EN]),
    .in_size    (in_tdata[O_SLOT-1:O_SZ]),
    .in_slot    (in_tdata[O_SLOT+IDX_W-1:O_SLOT]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (r_status),
    .out_index  (r_index),
    .out_owner  (r_owner),
    .out_start  (r_start),
    .out_end    (r_end),
    .out_count  (r_count)
  );

  // pack result fields, lowest first, zero padded to whole bytes
  assign out_tdata = OUT_TW'({r_count, r_end, r_start, r_owner, r_index, r_status});

endmodule

// ===== dv/tb.sv =====
module tb;
  import aofbt_pkg::*;

  localparam int TAB_DEPTH = 64;
  localparam int IN_TW     = 72;
  localparam int OUT_TW    = 64;
  localparam int N_RANDOM  = 1700;
  localparam int CYCLE_LIMIT = 1500000;

  // operation code with no meaning in the block
  localparam logic [2:0] OP_UNDEF = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  owner;
    logic [15:0] bstart;
    logic [15:0] bend;
    logic [16:0] want;
    logic [5:0]  slot;
  } op_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  fidx;
    logic [7:0]  owner;
    logic [15:0] bstart;
    logic [15:0] bend;
    logic [6:0]  count;
  } res_item_t;

  // directed row: item plus an optional typed-in result
  typedef struct {
    op_item_t  item;
    bit        typed;
    res_item_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  address_ordered_free_block_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // op, owner, start, end, size request, slot (low first)
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)  // status, index, owner, start, end, count (low first)
  );

  initial forever #5 clk = ~clk;

  // shadow table of the block
  logic [7:0]  tab_owner [TAB_DEPTH];
  logic [15:0] tab_start [TAB_DEPTH];
  logic [15:0] tab_end   [TAB_DEPTH];
  int          tab_count;

  res_item_t pending_results[$];
  int   n_errors = 0;
  int   n_seen = 0;
  int   cycles = 0;
  bit   no_idle = 1'b0;
  bit   hold_rx = 1'b0;
  int   op_hits[8];

  function automatic logic [IN_TW-1:0] pack_item(op_item_t it);
    logic [IN_TW-1:0] v;
    v = '0;
    v[2:0]   = it.op;
    v[10:3]  = it.owner;
    v[26:11] = it.bstart;
    v[42:27] = it.bend;
    v[59:43] = it.want;
    v[65:60] = it.slot;
    return v;
  endfunction

  function automatic res_item_t unpack_res(logic [OUT_TW-1:0] v);
    res_item_t r;
    r.status = v[1:0];
    r.fidx   = v[7:2];
    r.owner  = v[15:8];
    r.bstart = v[31:16];
    r.bend   = v[47:32];
    r.count  = v[54:48];
    return r;
  endfunction

  // table behavior, one operation
  function automatic res_item_t table_apply(op_item_t it);
    res_item_t r;
    int pos, keep;
    bit hit;
    longint sz;
    r = '0;
    r.status = ST_MISS;
    case (it.op)
      OP_INSERT: begin
        if (tab_count >= TAB_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tab_count && it.bstart > tab_start[pos]) pos++;
          for (int i = tab_count; i > pos; i--) begin
            tab_owner[i] = tab_owner[i-1];
            tab_start[i] = tab_start[i-1];
            tab_end[i]   = tab_end[i-1];
          end
          tab_owner[pos] = it.owner;
          tab_start[pos] = it.bstart;
          tab_end[pos]   = it.bend;
          tab_count++;
          r.status = ST_OK; r.fidx = pos[5:0];
          r.owner = it.owner; r.bstart = it.bstart; r.bend = it.bend;
        end
      end
      OP_COALESCE: begin
        if (tab_count >= 2) begin
          keep = 0;
          for (int s = 1; s < tab_count; s++) begin
            if ({1'b0, tab_end[keep]} + 17'd1 == {1'b0, tab_start[s]}) begin
              tab_end[keep] = tab_end[s];
            end else begin
              keep++;
              tab_owner[keep] = tab_owner[s];
              tab_start[keep] = tab_start[s];
              tab_end[keep]   = tab_end[s];
            end
          end
          tab_count = keep + 1;
        end
        r.status = ST_OK;
      end
      OP_FIND_SIZE, OP_FIND_OWNER, OP_FIND_EXACT: begin
        for (int i = 0; i < tab_count; i++) begin
          if (it.op == OP_FIND_SIZE) begin
            sz = longint'(tab_end[i]) - longint'(tab_start[i]) + 1;
            hit = longint'(it.want) <= sz;
          end else if (it.op == OP_FIND_OWNER) begin
            hit = tab_owner[i] == it.owner;
          end else begin
            hit = tab_owner[i] == it.owner && tab_start[i] == it.bstart &&
                  tab_end[i] == it.bend;
          end
          if (hit) begin
            r.status = ST_OK; r.fidx = i[5:0]; r.owner = tab_owner[i];
            r.bstart = tab_start[i]; r.bend = tab_end[i];
            break;
          end
        end
      end
      OP_REMOVE_AT, OP_READ_AT: begin
        if (int'(it.slot) < tab_count) begin
          pos = it.slot;
          r.status = ST_OK; r.fidx = it.slot; r.owner = tab_owner[pos];
          r.bstart = tab_start[pos]; r.bend = tab_end[pos];
          if (it.op == OP_REMOVE_AT) begin
            for (int i = pos; i + 1 < tab_count; i++) begin
              tab_owner[i] = tab_owner[i+1];
              tab_start[i] = tab_start[i+1];
              tab_end[i]   = tab_end[i+1];
            end
            tab_count--;
          end
        end
      end
      default: ;
    endcase
    r.count = tab_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want_v);
    $display("mismatch on result %0d: %s got %0h expected %0h", n_seen, what, got, want_v);
    n_errors++;
  endtask

  // sender gap: valid drops for the length of the gap
  task automatic idle_gap();
    int n;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // send one item; typed-in result overrides the predictor when given
  task automatic send_item(op_item_t it, bit typed, res_item_t res);
    res_item_t pr;
    idle_gap();
    in_tdata  <= pack_item(it);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pr = table_apply(it);
    op_hits[it.op]++;
    pending_results.push_back(typed ? res : pr);
    if (typed && res != pr) begin
      $display("directed row op %0d disagrees with shadow table", it.op);
      n_errors++;
    end
    @(negedge clk);
  endtask

  function automatic op_item_t mk(logic [2:0] op, logic [7:0] ow, logic [15:0] s,
                                  logic [15:0] e, logic [16:0] w, logic [5:0] sl);
    op_item_t it;
    it.op = op; it.owner = ow; it.bstart = s; it.bend = e; it.want = w; it.slot = sl;
    return it;
  endfunction

  function automatic res_item_t mr(logic [1:0] st, logic [5:0] fi, logic [7:0] ow,
                                   logic [15:0] s, logic [15:0] e, logic [6:0] c);
    res_item_t r;
    r.status = st; r.fidx = fi; r.owner = ow; r.bstart = s; r.bend = e; r.count = c;
    return r;
  endfunction

  // random item, mostly well-formed, biased toward a live table
  function automatic op_item_t rand_item();
    op_item_t it;
    int k, pick;
    it = '0;
    it.owner  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    it.bstart = 16'($urandom);
    it.bend   = it.bstart + 16'($urandom_range(0, 40));
    if ($urandom_range(0, 15) == 0) it.bend = 16'($urandom);
    it.want   = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(1, 48));
    it.slot   = 6'($urandom_range(0, (tab_count > 0) ? tab_count + 1 : 3));
    if ($urandom_range(0, 15) == 0) it.slot = 6'($urandom);
    k = $urandom_range(0, 99);
    if (k < 35) begin
      it.op = OP_INSERT;
      // place next to an existing block so coalescing has work
      if (tab_count > 0 && $urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, tab_count - 1);
        it.bstart = tab_end[pick] + 16'd1;
        it.bend   = it.bstart + 16'($urandom_range(0, 20));
      end
    end
    else if (k < 45) it.op = OP_COALESCE;
    else if (k < 55) it.op = OP_FIND_SIZE;
    else if (k < 63) it.op = OP_FIND_OWNER;
    else if (k < 78) it.op = OP_REMOVE_AT;
    else if (k < 88) it.op = OP_READ_AT;
    else if (k < 97) begin
      it.op = OP_FIND_EXACT;
      if (tab_count > 0 && $urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, tab_count - 1);
        it.owner = tab_owner[pick]; it.bstart = tab_start[pick]; it.bend = tab_end[pick];
      end
    end
    else it.op = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // result side: random stalls and one long hold-off
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) out_tready <= 1'b0;
      else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end else out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    res_item_t got, want_r;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_res(out_tdata);
      if (pending_results.size() == 0) begin
        $display("result %0d arrived with nothing expected", n_seen);
        n_errors++;
      end else begin
        want_r = pending_results.pop_front();
        if (got.status != want_r.status) report_mismatch("status", got.status, want_r.status);
        if (got.fidx   != want_r.fidx)   report_mismatch("index", got.fidx, want_r.fidx);
        if (got.owner  != want_r.owner)  report_mismatch("owner", got.owner, want_r.owner);
        if (got.bstart != want_r.bstart) report_mismatch("start", got.bstart, want_r.bstart);
        if (got.bend   != want_r.bend)   report_mismatch("end", got.bend, want_r.bend);
        if (got.count  != want_r.count)  report_mismatch("count", got.count, want_r.count);
      end
      n_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // long receiver hold-off, counted on its own
  initial begin
    wait (n_seen > 300);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  dir_row_t dir_rows[$];
  res_item_t nores = '0;

  initial begin
    op_item_t it;
    // directed table
    dir_rows.push_back('{mk(OP_READ_AT, 0, 0, 0, 1, 0), 1, mr(ST_MISS, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(OP_FIND_SIZE, 0, 0, 0, 1, 0), 1, mr(ST_MISS, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(OP_COALESCE, 0, 0, 0, 1, 0), 1, mr(ST_OK, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(OP_INSERT, 8'hff, 16'hfff0, 16'hffff, 1, 0), 1,
                         mr(ST_OK, 0, 8'hff, 16'hfff0, 16'hffff, 1)});
    dir_rows.push_back('{mk(OP_INSERT, 8'h00, 16'h0000, 16'h0000, 1, 0), 1,
                         mr(ST_OK, 0, 0, 0, 0, 2)});
    dir_rows.push_back('{mk(OP_INSERT, 8'h12, 16'h0001, 16'h000f, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_INSERT, 8'h34, 16'h0010, 16'h0008, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_INSERT, 8'h56, 16'h0010, 16'h0020, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_FIND_SIZE, 0, 0, 0, 17'h10000, 0), 0, nores});
    dir_rows.push_back('{mk(OP_FIND_SIZE, 0, 0, 0, 17'h1ffff, 0), 0, nores});
    dir_rows.push_back('{mk(OP_FIND_SIZE, 0, 0, 0, 17'd0, 0), 0, nores});
    dir_rows.push_back('{mk(OP_FIND_OWNER, 8'h34, 0, 0, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_FIND_EXACT, 8'h56, 16'h0010, 16'h0020, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_FIND_EXACT, 8'h57, 16'h0010, 16'h0020, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_COALESCE, 0, 0, 0, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_READ_AT, 0, 0, 0, 1, 6'd63), 0, nores});
    dir_rows.push_back('{mk(OP_UNDEF, 8'hff, 16'hffff, 16'hffff, 17'h1ffff, 6'd63), 0, nores});
    dir_rows.push_back('{mk(OP_READ_AT, 0, 0, 0, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_REMOVE_AT, 0, 0, 0, 1, 0), 0, nores});
    dir_rows.push_back('{mk(OP_REMOVE_AT, 0, 0, 0, 1, 6'd40), 0, nores});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tab_count = 0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // fill to full, prove the full flag, then drain
    while (tab_count < TAB_DEPTH) begin
      it = mk(OP_INSERT, 8'($urandom), 16'($urandom), 16'($urandom), 1, 0);
      send_item(it, 0, nores);
    end
    send_item(mk(OP_INSERT, 8'hab, 16'h1234, 16'h5678, 1, 0), 1,
              mr(ST_FULL, 0, 0, 0, 0, 7'd64));
    send_item(mk(OP_READ_AT, 0, 0, 0, 1, 6'd63), 0, nores);
    send_item(mk(OP_COALESCE, 0, 0, 0, 1, 0), 0, nores);
    while (tab_count > 0) send_item(mk(OP_REMOVE_AT, 0, 0, 0, 1,
                                       6'($urandom_range(0, tab_count - 1))), 0, nores);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 200) no_idle = 1'b1;
      send_item(rand_item(), 0, nores);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d results: inserts %0d, coalesces %0d, size %0d, owner %0d",
             n_seen, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("removes %0d, reads %0d, exact %0d, unknown %0d, incl. full table and long stall",
             op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
